/* sv/bhq_pkg.sv */
// Shared widths, codes and the result record of the binary min-heap queue.
package bhq_pkg;

  localparam int KEY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd1;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] min_key;
    logic [ENTRIES_W-1:0]    entries;
  } result_t;

endpackage

/* sv/bhq_ram.sv */
// Generic synchronous RAM with one write port and two registered read ports.
module bhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_a,
  output logic [WIDTH-1:0]                          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* sv/bhq_core.sv */
// Request sequencer of the heap queue: sift-up and sift-down over the heap RAM.
module bhq_core #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic signed [bhq_pkg::KEY_W-1:0] in_key,
  output logic                             res_valid,
  input  logic                             res_ready,
  output bhq_pkg::result_t                 res,
  output logic                             ram_we,
  output logic [$clog2(DEPTH)-1:0]         ram_waddr,
  output logic [bhq_pkg::KEY_W-1:0]        ram_wdata,
  output logic [$clog2(DEPTH)-1:0]         ram_raddr_a,
  output logic [$clog2(DEPTH)-1:0]         ram_raddr_b,
  input  logic [bhq_pkg::KEY_W-1:0]        ram_rdata_a,
  input  logic [bhq_pkg::KEY_W-1:0]        ram_rdata_b
);

  import bhq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DOWN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] idx);
    logic [AW-1:0] dec;
    dec = idx - AW'(1);
    return dec >> 1;
  endfunction

  function automatic logic [XW-1:0] left_of(input logic [AW-1:0] idx);
    return (XW'(idx) << 1) + XW'(1);
  endfunction

  logic [2:0]              state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [AW-1:0]           pos, pos_next;
  logic signed [KEY_W-1:0] key_hold, key_hold_next;
  logic [STATUS_W-1:0]     res_status, res_status_next;
  logic signed [KEY_W-1:0] res_min, res_min_next;

  logic [XW-1:0]           lc, rc, best_x, best_lc;
  logic [AW-1:0]           best;
  logic                    l_lt, r_lt;
  logic signed [KEY_W-1:0] left_key, right_key, l_min, best_val;

  assign left_key  = $signed(ram_rdata_a);
  assign right_key = $signed(ram_rdata_b);
  assign lc        = left_of(pos);
  assign rc        = lc + XW'(1);
  // Only children below the entry count take part in the comparison.
  assign l_lt      = (lc < XW'(count)) && (left_key < key_hold);
  assign l_min     = l_lt ? left_key : key_hold;
  assign r_lt      = (rc < XW'(count)) && (right_key < l_min);
  assign best_x    = r_lt ? rc : lc;
  assign best      = best_x[AW-1:0];
  assign best_val  = r_lt ? right_key : left_key;
  assign best_lc   = left_of(best);

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    key_hold_next   = key_hold;
    res_status_next = res_status;
    res_min_next    = res_min;
    ram_we          = 1'b0;
    ram_waddr       = pos;
    ram_wdata       = key_hold;
    ram_raddr_a     = '0;
    ram_raddr_b     = '0;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_status_next = STATUS_OK;
          res_min_next    = '0;
          if (in_kind == KIND_INSERT) begin
            if (count >= FULL_COUNT) begin
              res_status_next = STATUS_FULL;
              state_next      = S_DONE;
            end else begin
              key_hold_next = in_key;
              count_next    = count + CW'(1);
              pos_next      = AW'(count);
              if (count == '0) begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = in_key;
                state_next = S_DONE;
              end else begin
                ram_raddr_a = parent_of(AW'(count));
                state_next  = S_UP;
              end
            end
          end else begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
              res_min_next    = EMPTY_KEY;
              state_next      = S_DONE;
            end else begin
              // Root and last entry are fetched together.
              ram_raddr_a = '0;
              ram_raddr_b = AW'(count - CW'(1));
              count_next  = count - CW'(1);
              pos_next    = '0;
              state_next  = S_LOAD;
            end
          end
        end
      end
      S_UP: begin
        ram_we = 1'b1;
        if (pos == '0) begin
          ram_wdata  = key_hold;
          state_next = S_DONE;
        end else if (key_hold < left_key) begin
          // The parent drops into the hole and the hole moves up a level.
          ram_wdata   = ram_rdata_a;
          pos_next    = parent_of(pos);
          ram_raddr_a = parent_of(parent_of(pos));
        end else begin
          ram_wdata  = key_hold;
          state_next = S_DONE;
        end
      end
      S_LOAD: begin
        res_min_next  = left_key;
        key_hold_next = right_key;
        if (count == '0) begin
          state_next = S_DONE;
        end else begin
          ram_raddr_a = lc[AW-1:0];
          ram_raddr_b = rc[AW-1:0];
          state_next  = S_DOWN;
        end
      end
      S_DOWN: begin
        ram_we = 1'b1;
        if (l_lt || r_lt) begin
          ram_wdata   = best_val;
          pos_next    = best;
          ram_raddr_a = best_lc[AW-1:0];
          ram_raddr_b = AW'(best_lc + XW'(1));
        end else begin
          ram_wdata  = key_hold;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    pos        <= pos_next;
    key_hold   <= key_hold_next;
    res_status <= res_status_next;
    res_min    <= res_min_next;
  end

  assign res.status  = res_status;
  assign res.min_key = res_min;
  assign res.entries = ENTRIES_W'(count);

endmodule

/* sv/binary_min_heap_queue_top.sv */
// Top level of the binary min-heap priority queue with stream ports.
// An insert sifts its key up level by level in the sift-up state and then finishes; an extract
// loads the root and the last entry, sifts the moved entry down level by level, then finishes.
// The core takes no new item until its result has moved on to the output register; each
// heap level takes one RAM read and one write.
// Reset (rst, synchronous) empties the queue and drops any waiting result; RAM is kept.
module binary_min_heap_queue_top #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [bhq_pkg::IN_TDATA_W-1:0]       s_tdata,  // key
  input  logic                                 s_tuser,  // kind
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [bhq_pkg::OUT_TDATA_W-1:0]      m_tdata,  // min_key, entries, zero pad
  output logic [bhq_pkg::STATUS_W-1:0]         m_tuser   // status
);

  import bhq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [KEY_W-1:0]  ram_wdata, ram_rdata_a, ram_rdata_b;

  logic              res_valid, res_ready;
  result_t           res;

  logic              out_valid;
  result_t           out_res;

  // The heap itself: one write and two reads per cycle, so that both children of a
  // node, or the root and the last entry, arrive together. Only entries below the
  // count are ever used, so the RAM needs no clearing after reset.
  bhq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  bhq_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_kind     (s_tuser),
    .in_key      ($signed(s_tdata[KEY_W-1:0])),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_wdata   (ram_wdata),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b)
  );

  // Output register: a finished result waits here while the core goes back to take
  // the next item, so the two sides of the block are decoupled.
  assign res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {(OUT_TDATA_W - KEY_W - ENTRIES_W)'(0), out_res.entries,
                     out_res.min_key};

endmodule

/* sv/bhq_checker.sv */
// Port-level assertions for the heap queue top level, and the bind that attaches them.
module bhq_checker #(
  parameter int DEPTH = 64
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bhq_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [bhq_pkg::STATUS_W-1:0]    m_tuser
);

  import bhq_pkg::*;

  localparam logic [ENTRIES_W-1:0] FULL_ENTRIES = ENTRIES_W'(DEPTH);

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An empty extract reports the marker key and no entries.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_EMPTY |->
      m_tdata[KEY_W-1:0] == EMPTY_KEY && m_tdata[KEY_W+ENTRIES_W-1:KEY_W] == '0)
    else $error("empty result malformed");

  // A refused insert reports a full heap and a zero key.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_FULL |->
      m_tdata[KEY_W+ENTRIES_W-1:KEY_W] == FULL_ENTRIES && m_tdata[KEY_W-1:0] == '0)
    else $error("full result malformed");

  // The block never accepts an item in the cycle right after it accepted one.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while the first is in progress");

endmodule

bind binary_min_heap_queue_top bhq_checker #(.DEPTH(DEPTH)) u_bhq_checker (.*);

/* bench/heap_result_checker.sv */
// Checker for the heap queue: mirrors the heap from accepted requests and compares every result.
`timescale 1ns / 1ps
module heap_result_checker #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [bhq_pkg::IN_TDATA_W-1:0]       s_tdata,  // key
  input  logic                                 s_tuser,  // kind
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [bhq_pkg::OUT_TDATA_W-1:0]      m_tdata,  // min_key, entries, zero pad
  input  logic [bhq_pkg::STATUS_W-1:0]         m_tuser,  // status
  output int                                   fail_count,
  output int                                   awaited
);
  import bhq_pkg::*;

  // Mirror of the queue contents, slot 0 being the root.
  logic signed [KEY_W-1:0] mirror_heap [DEPTH];
  int                      mirror_held;
  result_t                 awaited_results [$];

  function automatic void swap_slots(int a, int b);
    logic signed [KEY_W-1:0] t;
    t              = mirror_heap[a];
    mirror_heap[a] = mirror_heap[b];
    mirror_heap[b] = t;
  endfunction

  function automatic result_t serve_request(logic kind, logic signed [KEY_W-1:0] key);
    result_t r;
    int      pos;
    int      up;
    int      best;
    int      lc;
    int      rc;
    r.status  = STATUS_OK;
    r.min_key = '0;
    if (kind == KIND_INSERT) begin
      if (mirror_held >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        mirror_heap[mirror_held] = key;
        mirror_held++;
        pos = mirror_held - 1;
        // An equal parent stops the climb.
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(mirror_heap[pos] < mirror_heap[up])) break;
          swap_slots(pos, up);
          pos = up;
        end
      end
    end else begin
      if (mirror_held == 0) begin
        r.status  = STATUS_EMPTY;
        r.min_key = EMPTY_KEY;
      end else begin
        r.min_key      = mirror_heap[0];
        mirror_heap[0] = mirror_heap[mirror_held - 1];
        mirror_held--;
        pos = 0;
        // Only a strictly smaller child is taken; the left one wins a tie.
        while (pos < mirror_held) begin
          best = pos;
          lc   = 2 * pos + 1;
          rc   = 2 * pos + 2;
          if (lc < mirror_held && mirror_heap[lc] < mirror_heap[best]) best = lc;
          if (rc < mirror_held && mirror_heap[rc] < mirror_heap[best]) best = rc;
          if (best == pos) break;
          swap_slots(pos, best);
          pos = best;
        end
      end
    end
    r.entries = ENTRIES_W'(mirror_held);
    return r;
  endfunction

  initial begin
    fail_count  = 0;
    awaited     = 0;
    mirror_held = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      awaited_results.delete();
      mirror_held = 0;
      awaited <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(serve_request(s_tuser, s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d key %0d entries %0d",
                   $time, m_tuser, $signed(m_tdata[31:0]), m_tdata[38:32]);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, m_tuser);
            fail_count++;
          end
          if (m_tdata[31:0] !== want.min_key) begin
            $display("%0t: min_key expected %0d, got %0d",
                     $time, want.min_key, $signed(m_tdata[31:0]));
            fail_count++;
          end
          if (m_tdata[38:32] !== want.entries) begin
            $display("%0t: entries expected %0d, got %0d", $time, want.entries, m_tdata[38:32]);
            fail_count++;
          end
          if (m_tdata[39] !== 1'b0) begin
            $display("%0t: pad bit expected 0, got %b", $time, m_tdata[39]);
            fail_count++;
          end
        end
      end
      awaited <= awaited_results.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Top of the heap queue testbench: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module tb_top;
  import bhq_pkg::*;

  localparam int DEPTH = 64;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata;   // key
  logic                    s_tuser;   // kind
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_TDATA_W-1:0]  m_tdata;   // min_key, entries, zero pad
  logic [STATUS_W-1:0]     m_tuser;   // status

  int fail_count;
  int awaited;

  // The sender keeps its own rough idea of the fill level so that it can steer
  // the random part towards a full heap and an empty one.
  int  fill_level;
  int  random_sent;
  bit  send_calm;
  bit  recv_calm;
  bit  paused_mid_run;

  binary_min_heap_queue_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  heap_result_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .fail_count(fail_count),
    .awaited   (awaited)
  );

  // 10 ns clock period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Keys are drawn from several pools: the full 32-bit range so that every bit
  // toggles, the two extremes with -1 and 0, and a narrow band around zero that
  // produces plenty of equal keys to exercise the tie rules of both sifts.
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 7))
      0, 1: k = $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: k = 32'sh8000_0000;
          1: k = 32'sh7fff_ffff;
          2: k = -32'sd1;
          default: k = 32'sd0;
        endcase
      end
      3, 4: k = int'($urandom_range(0, 8)) - 4;
      default: k = int'($urandom_range(0, 2000)) - 1000;
    endcase
    return k;
  endfunction

  // Offers one item and holds it until the block takes it. A gap of idle cycles
  // is drawn first unless the sender is in one of its calm stretches. The valid
  // line is only lowered when a gap is actually inserted, so it never drops and
  // rises within the same time step.
  task automatic send_item(input logic kind, input logic signed [KEY_W-1:0] key);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (kind == KIND_INSERT) begin
      if (fill_level < DEPTH) fill_level++;
    end else begin
      if (fill_level > 0) fill_level--;
    end
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
  endtask

  // The sender stops offering items until every awaited result has come back.
  task automatic hold_until_drained();
    s_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  // Random item mostly of the wanted kind, with a share of the other kind as noise.
  task automatic send_biased(input int insert_percent);
    if ($urandom_range(1, 100) <= insert_percent) send_item(KIND_INSERT, pick_key());
    else send_item(KIND_EXTRACT, pick_key());
    random_sent++;
  endtask

  // Result side: before each result it may hold tready low for a drawn number of
  // cycles, except in calm stretches, where tready simply stays high.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
    end
  end

  // Stimulus and verdict.
  initial begin
    int extra;
    int span;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = KIND_INSERT;
    fill_level     = 0;
    random_sent    = 0;
    send_calm      = 1'b0;
    recv_calm      = 1'b0;
    paused_mid_run = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed part. An extract from the fresh, empty heap comes first.
    send_item(KIND_EXTRACT, 32'sd0);
    // Both key extremes, -1 and zero, followed by a run of equal keys.
    send_item(KIND_INSERT, 32'sh7fff_ffff);
    send_item(KIND_INSERT, 32'sh8000_0000);
    send_item(KIND_INSERT, -32'sd1);
    send_item(KIND_INSERT, 32'sd0);
    send_item(KIND_INSERT, 32'sd5);
    send_item(KIND_INSERT, 32'sd5);
    send_item(KIND_INSERT, 32'sd5);
    send_item(KIND_INSERT, -32'sd7);
    // Drain the lot; the equal keys must come out one by one, and the key bits
    // of an extract are deliberately all ones to show they are ignored.
    repeat (8) send_item(KIND_EXTRACT, 32'shffff_ffff);
    // Extract from a heap that has just been emptied.
    send_item(KIND_EXTRACT, 32'sd0);
    send_item(KIND_INSERT, 32'shaaaa_aaaa);
    send_item(KIND_INSERT, 32'sh5555_5555);
    send_item(KIND_EXTRACT, 32'sd0);
    send_item(KIND_EXTRACT, 32'sd0);

    // Let every directed result arrive before the random part begins.
    hold_until_drained();

    // Random part in segments. The first segment fills the heap to the brim and
    // then tries to overfill it; later segments are chosen at random between
    // filling, draining past empty, and an even mix.
    span = 0;
    while (random_sent < 750) begin
      case ((random_sent == 0) ? 0 : $urandom_range(0, 2))
        0: begin
          while (fill_level < DEPTH) send_biased(90);
          extra = $urandom_range(1, 3);
          repeat (extra) send_biased(100);
        end
        1: begin
          while (fill_level > 0) send_biased(10);
          extra = $urandom_range(1, 2);
          repeat (extra) send_biased(0);
        end
        default: begin
          span = $urandom_range(20, 60);
          repeat (span) send_biased(50);
        end
      endcase
      // Part-way through, the sender waits once more for the block to catch up.
      if (!paused_mid_run && random_sent >= 400) begin
        hold_until_drained();
        paused_mid_run = 1'b1;
      end
    end

    // Wait for the last results, then allow a short tail for anything stray.
    s_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, set well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
